/* rtl/rpst_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the range-add power-sum block.
package rpst_pkg;

	localparam int VAL_W     = 30;
	localparam int RANGE_W   = 11;
	localparam int MUL_STEPS = VAL_W;
	localparam int CNT_W     = $clog2(MUL_STEPS + 1);

	localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_DATA,
		ST_SQ,
		ST_CU,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

/* rtl/rpst_if.sv */
`timescale 1ns / 1ps
// Channel interfaces: request items in, power-sum results out.
interface rpst_req_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [rpst_pkg::RANGE_W-1:0] range_left;
	logic [rpst_pkg::RANGE_W-1:0] range_right;
	logic [rpst_pkg::VAL_W-1:0]   addend;

	modport source (output valid, op, range_left, range_right, addend, input ready);
	modport sink (input valid, op, range_left, range_right, addend, output ready);
endinterface

interface rpst_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rpst_pkg::VAL_W-1:0] sum_first;
	logic [rpst_pkg::VAL_W-1:0] sum_squares;
	logic [rpst_pkg::VAL_W-1:0] sum_cubes;

	modport source (output valid, sum_first, sum_squares, sum_cubes, input ready);
	modport sink (input valid, sum_first, sum_squares, sum_cubes, output ready);
endinterface

/* rtl/rpst_modmul.sv */
`timescale 1ns / 1ps
// Bit-serial modular multiplier: one multiplier bit per cycle, reduced each step.
module rpst_modmul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rpst_pkg::VAL_W-1:0] a,
	input  logic [rpst_pkg::VAL_W-1:0] b,
	output logic [rpst_pkg::VAL_W-1:0] result,
	output rpst_pkg::mul_stat_t        stat
);

	localparam int VW = rpst_pkg::VAL_W;

	logic [VW-1:0]              a_q;
	logic [VW-1:0]              b_q;
	logic [VW-1:0]              r_q;
	logic [rpst_pkg::CNT_W-1:0] cnt_q;
	logic                       done_q;
	logic [VW+1:0]              t;
	logic [VW+1:0]              r_d;

	// Horner step: r = 2r + bit*a, which stays below 3p, then fold back below p.
	always_comb begin
		t = {1'b0, r_q, 1'b0} + (b_q[VW-1] ? {2'b00, a_q} : '0);
		if (t >= {1'b0, rpst_pkg::PRIME, 1'b0}) begin
			r_d = t - {1'b0, rpst_pkg::PRIME, 1'b0};
		end else if (t >= {2'b00, rpst_pkg::PRIME}) begin
			r_d = t - {2'b00, rpst_pkg::PRIME};
		end else begin
			r_d = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= rpst_pkg::CNT_W'(rpst_pkg::MUL_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rpst_pkg::CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (cnt_q != '0) begin
			r_q <= r_d[VW-1:0];
			b_q <= {b_q[VW-2:0], 1'b0};
		end
	end

	assign result = r_q;
	assign stat   = '{busy: (cnt_q != '0), done: done_q};

endmodule

/* rtl/rpst_mem.sv */
`timescale 1ns / 1ps
// Element store: one write port and one registered read port.
module rpst_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [rpst_pkg::VAL_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [rpst_pkg::VAL_W-1:0] rd_data
);

	logic [rpst_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic [rpst_pkg::VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/range_add_power_sum_tree.sv */
`timescale 1ns / 1ps
// Top level of the range-add power-sum block: sequencer, element store and multiplier.
//
//   channel  role    payload                                   transaction
//   req      sink    op, range_left, range_right, addend       one add or query item
//   rsp      source  sum_first, sum_squares, sum_cubes         one result per query
//
// After reset a clearing pass writes zero to every element, one element per cycle, over
// the padded array (the smallest power of two not below ENTRIES, and at least two); req is
// held off until it ends. An add reads and then writes back each element in the range,
// in the states RD and DATA, bound by the registered read port of the element store.
// A query is bound by the bit-serial modular multiplier, which forms the
// square and then the cube of each element in 30 steps each. An empty range finishes
// at once. Results wait in an output register; a stalled rsp holds the next query
// only at its end, while the sequencer is free to take further items up to then.
module range_add_power_sum_tree #(
	parameter int ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	rpst_req_if.sink    req,
	rpst_rsp_if.source  rsp
);

	localparam int VW   = rpst_pkg::VAL_W;
	localparam int RW   = rpst_pkg::RANGE_W;
	localparam int IW   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	localparam int TREE = 1 << IW;
	// Index counters hold the padded size itself, hence one bit more.
	localparam int XW   = IW + 1;
	localparam int CW   = (XW > RW) ? XW : RW;

	rpst_pkg::state_t    state_q, state_d;
	rpst_pkg::mul_stat_t mul_stat;

	logic          op_q;
	logic [XW-1:0] idx_q;
	logic [XW-1:0] idx_nx;
	logic [XW-1:0] right_q;
	logic [VW-1:0] addend_q;
	logic [VW-1:0] x_q;
	logic [VW-1:0] acc0_q, acc1_q, acc2_q;

	logic          out_valid_q;
	logic [VW-1:0] out0_q, out1_q, out2_q;

	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [VW-1:0] mem_wd;
	logic [VW-1:0] mem_rd;

	logic          mul_start;
	logic [VW-1:0] mul_a, mul_b;
	logic [VW-1:0] mul_res;

	logic          accept;
	logic          out_load;
	logic [CW-1:0] left_c, right_c;
	logic [XW-1:0] left_x, right_x;
	logic [VW-1:0] addend_red;
	logic          last;

	// Range bounds are clipped to the padded array size; the addend is reduced once,
	// which suffices because its field is below twice the prime.
	always_comb begin
		left_c  = CW'(req.range_left);
		right_c = CW'(req.range_right);
		left_x  = (left_c > CW'(TREE)) ? XW'(TREE) : left_c[XW-1:0];
		right_x = (right_c > CW'(TREE)) ? XW'(TREE) : right_c[XW-1:0];
		addend_red = (req.addend >= rpst_pkg::PRIME) ?
			(req.addend - rpst_pkg::PRIME) : req.addend;
	end

	assign idx_nx = idx_q + 1'b1;
	assign last   = (idx_nx == right_q);
	assign accept = req.valid && req.ready;

	rpst_mem #(
		.DEPTH (TREE),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_addr (idx_q[IW-1:0]),
		.rd_data (mem_rd)
	);

	rpst_modmul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.result (mul_res),
		.stat   (mul_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the strobes to the store and the multiplier.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = idx_q[IW-1:0];
		mem_wd    = '0;
		mul_start = 1'b0;
		mul_a     = mem_rd;
		mul_b     = mem_rd;
		out_load  = 1'b0;
		case (state_q)
			rpst_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (idx_q == XW'(TREE - 1)) begin
					state_d = rpst_pkg::ST_IDLE;
				end
			end
			rpst_pkg::ST_IDLE: begin
				req.ready = !mul_stat.busy;
				if (req.valid && !mul_stat.busy) begin
					if (left_x < right_x) begin
						state_d = rpst_pkg::ST_RD;
					end else if (req.op == rpst_pkg::OP_QUERY) begin
						state_d = rpst_pkg::ST_OUT;
					end
				end
			end
			rpst_pkg::ST_RD: begin
				state_d = rpst_pkg::ST_DATA;
			end
			rpst_pkg::ST_DATA: begin
				if (op_q == rpst_pkg::OP_QUERY) begin
					mul_start = 1'b1;
					state_d   = rpst_pkg::ST_SQ;
				end else begin
					mem_we  = 1'b1;
					mem_wd  = rpst_pkg::mod_add(mem_rd, addend_q);
					state_d = last ? rpst_pkg::ST_IDLE : rpst_pkg::ST_RD;
				end
			end
			rpst_pkg::ST_SQ: begin
				// Once the square is ready, multiply it by the element once more.
				mul_a = mul_res;
				mul_b = x_q;
				if (mul_stat.done) begin
					mul_start = 1'b1;
					state_d   = rpst_pkg::ST_CU;
				end
			end
			rpst_pkg::ST_CU: begin
				if (mul_stat.done) begin
					state_d = last ? rpst_pkg::ST_OUT : rpst_pkg::ST_RD;
				end
			end
			rpst_pkg::ST_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = rpst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpst_pkg::ST_IDLE;
			end
		endcase
	end

	// The element counter also sweeps the store during the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == rpst_pkg::ST_CLEAR) begin
			idx_q <= idx_nx;
		end else if (accept) begin
			idx_q <= left_x;
		end else if ((state_q == rpst_pkg::ST_DATA && op_q == rpst_pkg::OP_ADD) ||
				(state_q == rpst_pkg::ST_CU && mul_stat.done)) begin
			idx_q <= idx_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.op;
			right_q  <= right_x;
			addend_q <= addend_red;
			acc0_q   <= '0;
			acc1_q   <= '0;
			acc2_q   <= '0;
		end else begin
			if (state_q == rpst_pkg::ST_DATA && op_q == rpst_pkg::OP_QUERY) begin
				x_q    <= mem_rd;
				acc0_q <= rpst_pkg::mod_add(acc0_q, mem_rd);
			end
			if (state_q == rpst_pkg::ST_SQ && mul_stat.done) begin
				acc1_q <= rpst_pkg::mod_add(acc1_q, mul_res);
			end
			if (state_q == rpst_pkg::ST_CU && mul_stat.done) begin
				acc2_q <= rpst_pkg::mod_add(acc2_q, mul_res);
			end
		end
	end

	// Output register: one result waits here while the sequencer moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out0_q <= acc0_q;
			out1_q <= acc1_q;
			out2_q <= acc2_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.sum_first   = out0_q;
	assign rsp.sum_squares = out1_q;
	assign rsp.sum_cubes   = out2_q;

endmodule

/* rtl/rpst_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the range-add power-sum block, bound to its top level.
module rpst_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [rpst_pkg::VAL_W-1:0] sum_first,
	input logic [rpst_pkg::VAL_W-1:0] sum_squares,
	input logic [rpst_pkg::VAL_W-1:0] sum_cubes
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(sum_first) && $stable(sum_squares) &&
			$stable(sum_cubes))
		else $error("result changed while stalled");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> sum_first < rpst_pkg::PRIME && sum_squares < rpst_pkg::PRIME &&
			sum_cubes < rpst_pkg::PRIME)
		else $error("result not reduced modulo the prime");

endmodule

bind range_add_power_sum_tree rpst_checker u_rpst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.sum_first   (rsp.sum_first),
	.sum_squares (rsp.sum_squares),
	.sum_cubes   (rsp.sum_cubes)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the range-add power-sum tree: directed rows, then random traffic.
module testbench;

	localparam int VAL_W   = rpst_pkg::VAL_W;
	localparam int RANGE_W = rpst_pkg::RANGE_W;

	// The array spans 1024 elements, which is already a power of two, so the
	// clipped tree size equals the number of elements.
	localparam int                NUM_ELEMS   = 1024;
	localparam longint unsigned   MODULUS     = 64'd1000000007;
	localparam int                RANDOM_ITEMS = 1550;
	localparam longint            CYCLE_LIMIT = 64'd6000000;
	localparam int                DRAIN_CYCLES = 3000;

	// One request transaction as driven on the req channel.
	typedef struct {
		rpst_pkg::op_t      op;
		logic [RANGE_W-1:0] left;
		logic [RANGE_W-1:0] right;
		logic [VAL_W-1:0]   addend;
	} request_t;

	// The three power sums that one query returns.
	typedef struct {
		logic [VAL_W-1:0] first;
		logic [VAL_W-1:0] squares;
		logic [VAL_W-1:0] cubes;
	} power_sums_t;

	// A row of the directed table. When fixed is set, the expected sums are
	// written in the row itself; otherwise they come from the array model.
	typedef struct {
		request_t    item;
		logic        fixed;
		power_sums_t sums;
	} directed_row_t;

	logic clk;
	logic arst_n;

	rpst_req_if req_ch ();
	rpst_rsp_if rsp_ch ();

	range_add_power_sum_tree #(
		.ENTRIES(1024)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Flat copy of the element array; a segment tree gives the same sums as
	// walking the elements one by one, which is what this model does.
	logic [VAL_W-1:0] element_values [NUM_ELEMS];
	power_sums_t      pending_sums [$];

	int     mismatch_count;
	int     items_sent;
	int     queries_checked;
	int     adds_sent;
	longint cycle_count;
	logic   quiet_stretch;

	directed_row_t directed_rows [$];

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	// Watchdog: a correct run ends far below this cycle count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results still expected", $time,
				pending_sums.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Clip both ends to the tree size, as the block does.
	function automatic int clip_index(input logic [RANGE_W-1:0] idx);
		return (int'(idx) > NUM_ELEMS) ? NUM_ELEMS : int'(idx);
	endfunction

	// Apply one accepted transaction to the array model. For a query, the
	// power sums over the clipped range are returned; an add returns zeros.
	function automatic power_sums_t model_transaction(input request_t item);
		int              lo;
		int              hi;
		longint unsigned inc;
		longint unsigned e;
		longint unsigned s1;
		longint unsigned s2;
		longint unsigned s3;
		power_sums_t     res;
		lo  = clip_index(item.left);
		hi  = clip_index(item.right);
		inc = longint'(item.addend) % MODULUS;
		s1  = 0;
		s2  = 0;
		s3  = 0;
		for (int i = lo; i < hi; i++) begin
			e = longint'(element_values[i]);
			if (item.op == rpst_pkg::OP_ADD) begin
				element_values[i] = VAL_W'((e + inc) % MODULUS);
			end else begin
				s1 = (s1 + e) % MODULUS;
				s2 = (s2 + (e * e) % MODULUS) % MODULUS;
				s3 = (s3 + (((e * e) % MODULUS) * e) % MODULUS) % MODULUS;
			end
		end
		res.first   = VAL_W'(s1);
		res.squares = VAL_W'(s2);
		res.cubes   = VAL_W'(s3);
		return res;
	endfunction

	// Draw a random transaction. Most are well-formed short ranges so that the
	// run stays fast; a few are wide ranges that may run past the end, and the rest
	// are noise with indexes past the end, reversed ranges and unreduced addends.
	function automatic request_t random_request();
		request_t item;
		int       kind;
		int       lo;
		int       span;
		kind        = $urandom_range(0, 99);
		item.op     = rpst_pkg::op_t'($urandom_range(0, 1));
		item.addend = VAL_W'($urandom);
		if (kind < 3) begin
			item.addend = VAL_W'($urandom_range(0, 1000000006));
		end
		if (kind < 80) begin
			lo   = $urandom_range(0, NUM_ELEMS - 1);
			span = (item.op == rpst_pkg::OP_ADD) ? $urandom_range(1, 64) :
				$urandom_range(1, 8);
			item.left  = RANGE_W'(lo);
			item.right = RANGE_W'((lo + span > NUM_ELEMS) ? NUM_ELEMS : lo + span);
		end else if (kind < 90) begin
			// Wide ranges: queries over them are slow, so they are rare.
			if (item.op == rpst_pkg::OP_QUERY && $urandom_range(0, 39) != 0) begin
				item.op = rpst_pkg::OP_ADD;
			end
			lo          = $urandom_range(0, NUM_ELEMS - 1);
			item.left   = RANGE_W'(lo);
			item.right  = RANGE_W'($urandom_range(lo + 1, 2047));
		end else begin
			item.left  = RANGE_W'($urandom);
			item.right = RANGE_W'($urandom);
			// A noisy query must not span many elements; turn it around.
			if (item.op == rpst_pkg::OP_QUERY &&
				clip_index(item.left) + 16 < clip_index(item.right)) begin
				item.left  = item.right;
				item.right = RANGE_W'($urandom_range(0, int'(item.left)));
			end
		end
		return item;
	endfunction

	function automatic directed_row_t row(input rpst_pkg::op_t op, input int left,
		input int right, input logic [VAL_W-1:0] addend, input logic fixed);
		directed_row_t r;
		r.item.op     = op;
		r.item.left   = RANGE_W'(left);
		r.item.right  = RANGE_W'(right);
		r.item.addend = addend;
		r.fixed       = fixed;
		r.sums        = '{first: '0, squares: '0, cubes: '0};
		return r;
	endfunction

	// Drive one transaction on req and wait for its acceptance. The gap before
	// it is drawn at random, except in quiet stretches. valid is lowered only
	// when a gap follows, so it never gets two assignments in one step.
	task automatic send_request(input request_t item, input logic fixed,
		input power_sums_t typed_sums);
		int          gap;
		power_sums_t predicted;
		gap = quiet_stretch ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= item.op;
		req_ch.range_left  <= item.left;
		req_ch.range_right <= item.right;
		req_ch.addend      <= item.addend;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		predicted = model_transaction(item);
		if (item.op == rpst_pkg::OP_QUERY) begin
			pending_sums.push_back(fixed ? typed_sums : predicted);
		end else begin
			adds_sent++;
		end
		items_sent++;
	endtask

	task automatic wait_results_drained();
		while (pending_sums.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Receiver side: hold ready low for a random number of cycles before each
	// result, with quiet stretches where it stays high.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet_stretch ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	// Result checker: every accepted result is compared with the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		power_sums_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_sums.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result first=%0d squares=%0d cubes=%0d", $time,
					rsp_ch.sum_first, rsp_ch.sum_squares, rsp_ch.sum_cubes);
			end else begin
				want = pending_sums.pop_front();
				queries_checked++;
				if (rsp_ch.sum_first !== want.first) begin
					mismatch_count++;
					$display("%0t: sum_first expected %0d actual %0d", $time,
						want.first, rsp_ch.sum_first);
				end
				if (rsp_ch.sum_squares !== want.squares) begin
					mismatch_count++;
					$display("%0t: sum_squares expected %0d actual %0d", $time,
						want.squares, rsp_ch.sum_squares);
				end
				if (rsp_ch.sum_cubes !== want.cubes) begin
					mismatch_count++;
					$display("%0t: sum_cubes expected %0d actual %0d", $time,
						want.cubes, rsp_ch.sum_cubes);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, drain, verdict.
	initial begin
		request_t    item;
		power_sums_t zero_sums;
		zero_sums = '{first: '0, squares: '0, cubes: '0};
		mismatch_count  = 0;
		items_sent      = 0;
		queries_checked = 0;
		adds_sent       = 0;
		cycle_count     = 0;
		quiet_stretch   = 1'b0;
		for (int i = 0; i < NUM_ELEMS; i++) begin
			element_values[i] = '0;
		end
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.op          <= rpst_pkg::OP_ADD;
		req_ch.range_left  <= '0;
		req_ch.range_right <= '0;
		req_ch.addend      <= '0;

		// The typed rows are those whose answer is plain: zeros right after
		// reset, and zeros for empty, reversed or fully clipped ranges.
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 0, 4, '0, 1'b1));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 5, 5, '0, 1'b1));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 9, 3, 30'h3FFF_FFFF, 1'b1));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 0, 1024, 30'd1000000006, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 0, 1, '0, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 0, 1, 30'h3FFF_FFFF, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 1023, 1024, 30'd1, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 2047, 2047, 30'd9, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 5, 3, 30'd7, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 0, 0, 30'd11, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 1000, 2047, 30'd5, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 1020, 2047, 30'h2AAA_AAAA, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 2047, 0, '0, 1'b1));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 1024, 2047, '0, 1'b1));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 0, 8, 30'h1555_5555, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_ADD, 3, 6, 30'd1000000007, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 2, 7, '0, 1'b0));
		directed_rows.push_back(row(rpst_pkg::OP_QUERY, 0, 2047, '0, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].item, directed_rows[i].fixed,
				directed_rows[i].sums);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Every hundred transactions decide whether the next stretch
			// runs with no gaps or stalls on either side.
			if (n % 100 == 0) begin
				quiet_stretch = ($urandom_range(0, 3) == 0);
			end
			// Halfway through, drop valid and let every outstanding result
			// come back before sending again.
			if (n == RANDOM_ITEMS / 2) begin
				req_ch.valid <= 1'b0;
				wait_results_drained();
				@(posedge clk);
			end
			item = random_request();
			send_request(item, 1'b0, zero_sums);
		end
		req_ch.valid <= 1'b0;

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions (%0d range adds), checked %0d query results.",
			items_sent, adds_sent, queries_checked);
		$display("Covered clipped, reversed and empty ranges, unreduced addends, full spans.");
		if (mismatch_count == 0 && pending_sums.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0t: %0d mismatches, %0d results never arrived", $time,
				mismatch_count, pending_sums.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
